/* hw/rtl/olist_pkg.sv */
// Types and codes shared by the ordered list engine.
`default_nettype none
package olist_pkg;

    localparam int OP_W        = 3;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 5;
    localparam int MAX_RESULTS = 16;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] result_value;
        logic [POS_W-1:0]         position;
        logic                     last;
    } t_res;

    typedef struct packed {
        logic ins;
        logic del;
        logic rot;
        logic pick_last;
    } t_mode;

endpackage
`default_nettype wire

/* hw/rtl/olist_cell.sv */
// One list cell: holds a word, shifts with its neighbours, matches the key.
`default_nettype none
module olist_cell #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire                   i_clk,
    input  olist_pkg::t_mode      i_mode,
    input  wire [IW-1:0]          i_pos,
    input  wire [IW-1:0]          i_last_idx,
    input  wire [CW-1:0]          i_len,
    input  wire [DATA_WIDTH-1:0]  i_wdata,
    input  wire [DATA_WIDTH-1:0]  i_key,
    input  wire [DATA_WIDTH-1:0]  i_left,
    input  wire [DATA_WIDTH-1:0]  i_right,
    input  wire [DATA_WIDTH-1:0]  i_first,
    input  wire                   i_seen,
    output logic                  o_seen,
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [IW-1:0] ME  = IW'(IDX);
    localparam logic [CW-1:0] MEC = CW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  match;

    always_comb begin
        n_data = r_data;
        if (i_mode.ins) begin
            if (ME > i_pos) begin
                n_data = i_left;
            end else if (ME == i_pos) begin
                n_data = i_wdata;
            end
        end else if (i_mode.del) begin
            if (ME >= i_pos) begin
                n_data = i_right;
            end
        end else if (i_mode.rot) begin
            n_data = (ME == i_last_idx) ? i_first : i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign match  = (r_data == i_key) && (MEC < i_len);
    assign o_seen = i_seen | match;
    assign o_hit  = i_mode.pick_last ? (ME == i_last_idx) : (match & ~i_seen);
    assign o_data = r_data;

endmodule
`default_nettype wire

/* hw/rtl/olist_chain.sv */
// Row of list cells with first-match pick and selected-word readout.
`default_nettype none
module olist_chain #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire                   i_clk,
    input  olist_pkg::t_mode      i_mode,
    input  wire [IW-1:0]          i_pos,
    input  wire [IW-1:0]          i_last_idx,
    input  wire [CW-1:0]          i_len,
    input  wire [DATA_WIDTH-1:0]  i_wdata,
    input  wire [DATA_WIDTH-1:0]  i_key,
    output logic                  o_found,
    output logic [IW-1:0]         o_rd_idx,
    output logic [DATA_WIDTH-1:0] o_rd_data,
    output logic [DATA_WIDTH-1:0] o_front
);

    logic [DATA_WIDTH-1:0] c_data [CAPACITY];
    logic                  c_hit  [CAPACITY];
    logic                  c_seen [CAPACITY+1];

    assign c_seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        olist_cell #(
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_mode     (i_mode),
            .i_pos      (i_pos),
            .i_last_idx (i_last_idx),
            .i_len      (i_len),
            .i_wdata    (i_wdata),
            .i_key      (i_key),
            .i_left     ((g == 0) ? i_wdata : c_data[(g == 0) ? 0 : g - 1]),
            .i_right    ((g == CAPACITY - 1) ? c_data[g]
                                             : c_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_first    (c_data[0]),
            .i_seen     (c_seen[g]),
            .o_seen     (c_seen[g+1]),
            .o_hit      (c_hit[g]),
            .o_data     (c_data[g])
        );
    end

    always_comb begin
        o_rd_data = '0;
        o_rd_idx  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (c_hit[i]) begin
                o_rd_data = o_rd_data | c_data[i];
                o_rd_idx  = o_rd_idx | IW'(i);
            end
        end
    end

    assign o_found = c_seen[CAPACITY];
    assign o_front = c_data[0];

endmodule
`default_nettype wire

/* hw/rtl/ordered_list_engine_top.sv */
// Top level of the ordered list engine: command decode, length and result words.
//
//  channel | ports                     | handshake
//  --------+---------------------------+--------------------------------------
//  command | i_cmd, start, busy        | word taken when start & !busy
//  result  | o_res, o_res_strobe       | word valid for one cycle on strobe
//
// Every command but a list is accepted, then the cell row shifts once
// with the key matched in all cells at once; the result shows the cycle
// after. A list keeps busy while the row rotates once round, one word per
// cycle, at most MAX_RESULTS words. Reset clears the length and the controller;
// cell contents are left as they are. The receiver cannot stall results.
`default_nettype none
module ordered_list_engine_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  olist_pkg::t_cmd    i_cmd,
    output logic               o_res_strobe,
    output olist_pkg::t_res    o_res
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]       r_state, n_state;
    olist_pkg::t_cmd  r_cmd;
    logic [CW-1:0]    r_len, n_len;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_lim, n_lim;
    logic             r_out_vld, n_out_vld;
    olist_pkg::t_res  r_out, n_out;

    olist_pkg::t_mode     mode;
    logic [IW-1:0]        pos;
    logic [IW-1:0]        last_idx;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] key;
    logic                 found;
    logic [IW-1:0]        rd_idx;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] front;
    logic                 full;
    logic                 empty;
    logic [PW-1:0]        pos_hit;
    logic [PW-1:0]        pos_cnt;

    assign wdata    = DATA_WIDTH'(r_cmd.value);
    assign key      = DATA_WIDTH'(r_cmd.key);
    assign last_idx = IW'(r_len - CW'(1));
    assign full     = (r_len == CW'(CAPACITY));
    assign empty    = (r_len == '0);
    assign pos_hit  = PW'(rd_idx) + PW'(1);
    assign pos_cnt  = PW'(r_cnt) + PW'(1);

    olist_chain #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_mode     (mode),
        .i_pos      (pos),
        .i_last_idx (last_idx),
        .i_len      (r_len),
        .i_wdata    (wdata),
        .i_key      (key),
        .o_found    (found),
        .o_rd_idx   (rd_idx),
        .o_rd_data  (rd_data),
        .o_front    (front)
    );

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_lim     = r_lim;
        n_out_vld = 1'b0;
        n_out     = r_out;
        mode      = '0;
        pos       = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state              = S_IDLE;
                n_out_vld            = 1'b1;
                n_out.status         = olist_pkg::ST_OK;
                n_out.result_value   = '0;
                n_out.position       = '0;
                n_out.last           = 1'b1;
                if ((r_cmd.operation == olist_pkg::OP_INS_FRONT ||
                     r_cmd.operation == olist_pkg::OP_INS_END ||
                     r_cmd.operation == olist_pkg::OP_INS_AFTER) && full) begin
                    n_out.status = olist_pkg::ST_FULL;
                end else if (r_cmd.operation >= olist_pkg::OP_INS_AFTER && empty) begin
                    n_out.status = olist_pkg::ST_EMPTY;
                end else begin
                    case (r_cmd.operation)
                        olist_pkg::OP_INS_FRONT: begin
                            mode.ins           = 1'b1;
                            pos                = '0;
                            n_len              = r_len + CW'(1);
                            n_out.result_value = olist_pkg::WORD_W'($signed(wdata));
                            n_out.position     = olist_pkg::POS_W'(1);
                        end
                        olist_pkg::OP_INS_END: begin
                            mode.ins           = 1'b1;
                            pos                = IW'(r_len);
                            n_len              = r_len + CW'(1);
                            n_out.result_value = olist_pkg::WORD_W'($signed(wdata));
                            n_out.position     = olist_pkg::POS_W'(PW'(r_len) + PW'(1));
                        end
                        olist_pkg::OP_INS_AFTER: begin
                            if (found) begin
                                mode.ins           = 1'b1;
                                pos                = rd_idx + IW'(1);
                                n_len              = r_len + CW'(1);
                                n_out.result_value = olist_pkg::WORD_W'($signed(wdata));
                                n_out.position     = olist_pkg::POS_W'(pos_hit + PW'(1));
                            end else begin
                                n_out.status = olist_pkg::ST_NOTFOUND;
                            end
                        end
                        olist_pkg::OP_DEL_FRONT: begin
                            mode.del           = 1'b1;
                            pos                = '0;
                            n_len              = r_len - CW'(1);
                            n_out.result_value = olist_pkg::WORD_W'($signed(front));
                            n_out.position     = olist_pkg::POS_W'(1);
                        end
                        olist_pkg::OP_DEL_END: begin
                            mode.del           = 1'b1;
                            mode.pick_last     = 1'b1;
                            pos                = last_idx;
                            n_len              = r_len - CW'(1);
                            n_out.result_value = olist_pkg::WORD_W'($signed(rd_data));
                            n_out.position     = olist_pkg::POS_W'(r_len);
                        end
                        olist_pkg::OP_DEL_KEY: begin
                            if (found) begin
                                mode.del           = 1'b1;
                                pos                = rd_idx;
                                n_len              = r_len - CW'(1);
                                n_out.result_value = olist_pkg::WORD_W'($signed(rd_data));
                                n_out.position     = olist_pkg::POS_W'(pos_hit);
                            end else begin
                                n_out.status = olist_pkg::ST_NOTFOUND;
                            end
                        end
                        olist_pkg::OP_SEARCH: begin
                            if (found) begin
                                n_out.result_value = olist_pkg::WORD_W'($signed(rd_data));
                                n_out.position     = olist_pkg::POS_W'(pos_hit);
                            end else begin
                                n_out.status = olist_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b0;
                            n_state   = S_LIST;
                            n_cnt     = '0;
                            n_lim     = (int'(r_len) < olist_pkg::MAX_RESULTS)
                                        ? r_len : CW'(olist_pkg::MAX_RESULTS);
                        end
                    endcase
                end
            end
            S_LIST: begin
                mode.rot = 1'b1;
                if (r_cnt < r_lim) begin
                    n_out_vld          = 1'b1;
                    n_out.status       = olist_pkg::ST_OK;
                    n_out.result_value = olist_pkg::WORD_W'($signed(front));
                    n_out.position     = olist_pkg::POS_W'(pos_cnt);
                    n_out.last         = (pos_cnt == PW'(r_lim));
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == r_len - CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_cnt     <= '0;
            r_lim     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_lim     <= n_lim;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_res_strobe = r_out_vld;
    assign o_res        = r_out;

endmodule
`default_nettype wire

/* hw/rtl/olist_checker.sv */
// Port checks for the ordered list engine and their bind to the top level.
`default_nettype none
module olist_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             start,
    input wire             busy,
    input wire             o_res_strobe,
    input olist_pkg::t_res o_res
);

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command was taken");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.status != olist_pkg::ST_OK |-> o_res.last)
        else $error("error word not marked last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.status != olist_pkg::ST_OK
        |-> o_res.result_value == '0 && o_res.position == '0)
        else $error("error word carries a value or position");

    a_list_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_res.last |-> busy ##1 o_res_strobe)
        else $error("list words not back to back");

endmodule

bind ordered_list_engine_top olist_checker u_olist_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);
`default_nettype wire

/* sim/ordered_list_engine_top_tb.sv */
// Self-checking testbench for the ordered list engine top level.
`timescale 1ns / 100ps
module ordered_list_engine_top_tb;
    import olist_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int PLAN_LEN   = 25;
    localparam int QUIET_MAX  = 2000;
    localparam int DRAIN_WAIT = 24;
    localparam int RAND_ITEMS = 140;

    typedef struct packed {
        t_cmd cmd;
        logic fixed;
        t_res res;
    } t_plan_row;

    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{'{OP_LIST,      32'sd0,          32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_DEL_FRONT, 32'sd0,          32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_DEL_END,   32'sd0,          32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_DEL_KEY,   32'sd0,          32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_SEARCH,    32'sd0,          32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_INS_AFTER, 32'sd4,          32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_INS_END,   32'sh8000_0000,  32'sh7fff_ffff},  1'b1,
          '{ST_OK, 32'sh8000_0000, 5'd1, 1'b1}},
        '{'{OP_INS_FRONT, 32'sh7fff_ffff,  32'sh8000_0000},  1'b1,
          '{ST_OK, 32'sh7fff_ffff, 5'd1, 1'b1}},
        '{'{OP_INS_END,   32'sd0,          -32'sd1},         1'b1, '{ST_OK, 32'sd0, 5'd3, 1'b1}},
        '{'{OP_INS_AFTER, -32'sd1,         32'sd0},          1'b1, '{ST_OK, -32'sd1, 5'd4, 1'b1}},
        '{'{OP_SEARCH,    32'sd0,          32'sd5},          1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_DEL_KEY,   32'sd0,          32'sd5},          1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_INS_AFTER, 32'sd6,          32'sd5},          1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0, 1'b1}},
        '{'{OP_LIST,      32'sd0,          32'sd0},          1'b0, '0},
        '{'{OP_SEARCH,    32'sd0,          32'sd0},          1'b0, '0},
        '{'{OP_DEL_KEY,   32'sd0,          32'sh8000_0000},  1'b0, '0},
        '{'{OP_DEL_FRONT, 32'sd0,          32'sd0},          1'b0, '0},
        '{'{OP_DEL_END,   32'sd0,          32'sd0},          1'b0, '0},
        '{'{OP_DEL_END,   32'sd0,          32'sd0},          1'b0, '0},
        '{'{OP_INS_FRONT, 32'sd7,          32'sd0},          1'b1, '{ST_OK, 32'sd7, 5'd1, 1'b1}},
        '{'{OP_INS_END,   32'sd7,          32'sd0},          1'b1, '{ST_OK, 32'sd7, 5'd2, 1'b1}},
        '{'{OP_INS_AFTER, 32'sd9,          32'sd7},          1'b0, '0},
        '{'{OP_SEARCH,    32'sd0,          32'sd7},          1'b0, '0},
        '{'{OP_DEL_KEY,   32'sd0,          32'sd7},          1'b0, '0},
        '{'{OP_LIST,      32'sd0,          32'sd0},          1'b0, '0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_res_strobe;
    t_res o_res;

    logic signed [WORD_W-1:0] shadow_words [CAPACITY];
    int unsigned              shadow_len;
    t_res                     pending_res [$];
    int unsigned              fill_goal;
    int unsigned              idle_pct;
    int unsigned              fail_count;
    int unsigned              quiet_cycles;

    ordered_list_engine_top #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(WORD_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_res res_word(input logic [STATUS_W-1:0] st,
                                      input logic signed [WORD_W-1:0] w,
                                      input int unsigned pos, input logic fin);
        t_res r;
        r.status       = st;
        r.result_value = w;
        r.position     = POS_W'(pos);
        r.last         = fin;
        return r;
    endfunction

    function automatic void shadow_insert(input int unsigned at,
                                          input logic signed [WORD_W-1:0] w);
        int unsigned i;
        for (i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i - 1];
        shadow_words[at] = w;
        shadow_len++;
    endfunction

    function automatic logic signed [WORD_W-1:0] shadow_remove(input int unsigned at);
        logic signed [WORD_W-1:0] w;
        int unsigned              i;
        w = shadow_words[at];
        for (i = at; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
        shadow_len--;
        return w;
    endfunction

    // Apply one command to the shadow list and queue the words it should produce.
    function automatic void list_apply(input t_cmd c);
        int                       hit;
        int unsigned              i;
        int unsigned              n;
        logic signed [WORD_W-1:0] w;
        hit = -1;
        for (i = 0; i < shadow_len; i++)
            if (hit < 0 && shadow_words[i] == c.key) hit = int'(i);
        if (c.operation <= OP_INS_AFTER && shadow_len >= CAPACITY) begin
            pending_res.push_back(res_word(ST_FULL, '0, 0, 1'b1));
        end else if (c.operation >= OP_INS_AFTER && shadow_len == 0) begin
            pending_res.push_back(res_word(ST_EMPTY, '0, 0, 1'b1));
        end else if ((c.operation == OP_INS_AFTER || c.operation == OP_DEL_KEY ||
                      c.operation == OP_SEARCH) && hit < 0) begin
            pending_res.push_back(res_word(ST_NOTFOUND, '0, 0, 1'b1));
        end else begin
            case (c.operation)
                OP_INS_FRONT: begin
                    shadow_insert(0, c.value);
                    pending_res.push_back(res_word(ST_OK, c.value, 1, 1'b1));
                end
                OP_INS_END: begin
                    shadow_insert(shadow_len, c.value);
                    pending_res.push_back(res_word(ST_OK, c.value, shadow_len, 1'b1));
                end
                OP_INS_AFTER: begin
                    shadow_insert(hit + 1, c.value);
                    pending_res.push_back(res_word(ST_OK, c.value, hit + 2, 1'b1));
                end
                OP_DEL_FRONT: begin
                    w = shadow_remove(0);
                    pending_res.push_back(res_word(ST_OK, w, 1, 1'b1));
                end
                OP_DEL_END: begin
                    n = shadow_len;
                    w = shadow_remove(n - 1);
                    pending_res.push_back(res_word(ST_OK, w, n, 1'b1));
                end
                OP_DEL_KEY: begin
                    w = shadow_remove(hit);
                    pending_res.push_back(res_word(ST_OK, w, hit + 1, 1'b1));
                end
                OP_SEARCH: begin
                    pending_res.push_back(res_word(ST_OK, shadow_words[hit], hit + 1, 1'b1));
                end
                default: begin
                    n = (shadow_len < MAX_RESULTS) ? shadow_len : MAX_RESULTS;
                    for (i = 0; i < n; i++)
                        pending_res.push_back(res_word(ST_OK, shadow_words[i], i + 1,
                                                       i + 1 == n));
                end
            endcase
        end
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(3, 0))
            0, 1:    return $urandom;
            2:       return $signed(WORD_W'($urandom_range(7, 0))) - 32'sd2;
            default: return $urandom_range(1, 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    // Grow towards fill_goal or shrink from it; keys mostly hit live entries.
    function automatic t_cmd next_cmd();
        t_cmd        c;
        int unsigned pick;
        int unsigned ins_top;
        pick    = $urandom_range(99, 0);
        ins_top = (shadow_len < fill_goal) ? 75 : 42;
        if (pick < 12)
            c.operation = OP_SEARCH;
        else if (pick < 20)
            c.operation = OP_LIST;
        else if (pick < ins_top)
            c.operation = OP_INS_FRONT + OP_W'($urandom_range(2, 0));
        else
            c.operation = OP_DEL_FRONT + OP_W'($urandom_range(2, 0));
        c.value = pick_word();
        if (shadow_len != 0 && $urandom_range(99, 0) < 70)
            c.key = shadow_words[$urandom_range(shadow_len - 1, 0)];
        else
            c.key = pick_word();
        return c;
    endfunction

    task automatic send_word(input t_cmd c, input logic fixed, input t_res fixed_res);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        list_apply(c);
        if (fixed) begin
            void'(pending_res.pop_back());
            pending_res.push_back(fixed_res);
        end
        if ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : res_check
        t_res want;
        if (i_rst_n && o_res_strobe === 1'b1) begin
            if (pending_res.size() == 0) begin
                $error("result word with none expected: %p", o_res);
                fail_count++;
            end else begin
                want = pending_res.pop_front();
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_res.status);
                    fail_count++;
                end
                if (o_res.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, o_res.result_value);
                    fail_count++;
                end
                if (o_res.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_res.position);
                    fail_count++;
                end
                if (o_res.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_res.last);
                    fail_count++;
                end
            end
        end
        if ((start && busy === 1'b0) || o_res_strobe === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        shadow_len   = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        idle_pct     = 14;
        fill_goal    = CAPACITY;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_LEN; r++)
            send_word(PLAN[r].cmd, PLAN[r].fixed, PLAN[r].res);

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 14 : (ph == 1) ? 55 : 0;
            for (int k = 0; k < RAND_ITEMS; k++) begin
                if (k % 30 == 0 && !(ph == 0 && k == 0)) begin
                    case ($urandom_range(2, 0))
                        0:       fill_goal = 0;
                        1:       fill_goal = CAPACITY;
                        default: fill_goal = $urandom_range(CAPACITY, 0);
                    endcase
                end
                send_word(next_cmd(), 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
